/* hw/rtl/fdcr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the floppy controller register block.
package fdcr_pkg;

    // Drive count default; the top level hands its parameter down.
    localparam int DRIVES_DEF        = 4;
    localparam int TRACKS            = 40;
    localparam int SECTORS_PER_TRACK = 10;
    localparam int BUFFER_BYTES      = 284;

    localparam logic [1:0] PULSE_RELOAD = 2'd2;
    localparam logic [7:0] CTRL_READY   = 8'h81;

    // Register addresses on the processor bus.
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_DATA    = 3'd1;
    localparam logic [2:0] REG_SECTOR  = 3'd2;
    localparam logic [2:0] REG_DRIVE   = 3'd3;
    localparam logic [2:0] REG_RESTART = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_ATTACHED  = 1'b0;
    localparam logic CFG_READ_ONLY = 1'b1;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_FETCH = 2'd1,
        ACC_STORE = 2'd2
    } t_acc;

    typedef struct packed {
        logic       action;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        t_acc       buffer_access;
        logic       sector_reload;
        logic [1:0] access_drive;
        logic [5:0] access_track;
        logic [3:0] access_sector;
        logic [8:0] access_index;
    } t_rsp;

    // Sector after one rotation step, wrapping at the end of the track.
    function automatic logic [3:0] f_next_sector(input logic [3:0] sec);
        logic [4:0] sum;
        sum = {1'b0, sec} + 5'd1;
        return (sum >= 5'(SECTORS_PER_TRACK)) ? 4'd0 : sum[3:0];
    endfunction

    // Head position after one step, held inside the track range.
    function automatic logic [5:0] f_step_track(input logic [5:0] trk, input logic up);
        logic [6:0] sum;
        sum = {1'b0, trk} + 7'd1;
        if (up) begin
            return (sum < 7'(TRACKS)) ? sum[5:0] : 6'(TRACKS - 1);
        end
        return (trk != 6'd0) ? (trk - 6'd1) : 6'd0;
    endfunction

endpackage

/* hw/rtl/fdcr_in_stage.sv */
`timescale 1ns / 1ps
// Input register that holds one bus request until the core consumes it.
module fdcr_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fdcr_pkg::t_req     i_req,
    input  logic               i_take,
    output logic               o_ready,
    output logic               o_valid,
    output fdcr_pkg::t_req     o_req
);

    logic           r_valid;
    fdcr_pkg::t_req r_req;

    // A held request leaving this cycle frees the slot for the next one.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

/* hw/rtl/fdcr_core.sv */
`timescale 1ns / 1ps
// Controller state, configuration masks and the per-request decode logic.
module fdcr_core #(
    parameter int DRIVES = fdcr_pkg::DRIVES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_fire,
    input  fdcr_pkg::t_req     i_req,
    output fdcr_pkg::t_rsp     o_rsp
);

    logic [3:0] r_attached;
    logic [3:0] r_read_only;
    logic [1:0] r_sel_drive;
    logic [1:0] r_countdown;
    logic       r_step_latch;
    logic [5:0] r_trk [DRIVES];
    logic [3:0] r_sec [DRIVES];
    logic [8:0] r_pos [DRIVES];

    logic [1:0] n_sel_drive;
    logic [1:0] n_countdown;
    logic       n_step_latch;
    logic [5:0] n_trk [DRIVES];
    logic [3:0] n_sec [DRIVES];
    logic [8:0] n_pos [DRIVES];

    logic [5:0] cur_trk;
    logic [3:0] cur_sec;
    logic [8:0] cur_pos;
    logic [5:0] stp_trk;
    logic [3:0] stp_sec;
    logic [1:0] new_drv;
    logic       disk;
    logic       ro;
    logic       pos_in_range;
    logic [3:0] sec_after;

    fdcr_pkg::t_rsp rsp;

    // Pending per-drive writes for this request.
    logic       pos_we;
    logic [8:0] pos_val;
    logic       sec_we;
    logic       step_we;

    assign new_drv = i_req.write_data[7:6];
    assign disk    = ({1'b0, r_sel_drive} < 3'(DRIVES)) && r_attached[r_sel_drive];
    assign ro      = r_read_only[r_sel_drive];

    // Pick the selected drive's and the newly addressed drive's state.
    always_comb begin
        cur_trk = '0;
        cur_sec = '0;
        cur_pos = '0;
        stp_trk = '0;
        stp_sec = '0;
        for (int i = 0; i < DRIVES; i++) begin
            if (r_sel_drive == 2'(i)) begin
                cur_trk = r_trk[i];
                cur_sec = r_sec[i];
                cur_pos = r_pos[i];
            end
            if (new_drv == 2'(i)) begin
                stp_trk = r_trk[i];
                stp_sec = r_sec[i];
            end
        end
    end

    assign pos_in_range = cur_pos < 9'(fdcr_pkg::BUFFER_BYTES);
    assign sec_after    = (r_countdown == 2'd0) ? fdcr_pkg::f_next_sector(cur_sec) : cur_sec;

    always_comb begin
        rsp          = '0;
        n_sel_drive  = r_sel_drive;
        n_countdown  = r_countdown;
        n_step_latch = r_step_latch;
        pos_we       = 1'b0;
        pos_val      = cur_pos + 9'd1;
        sec_we       = 1'b0;
        step_we      = 1'b0;

        case (i_req.reg_addr)
            fdcr_pkg::REG_CTRL: begin
                if (!i_req.action) begin
                    rsp.read_data = fdcr_pkg::CTRL_READY;
                end
            end
            fdcr_pkg::REG_DATA: begin
                if (disk && pos_in_range) begin
                    if (!i_req.action) begin
                        rsp.buffer_access = fdcr_pkg::ACC_FETCH;
                        rsp.sector_reload = (cur_pos == 9'd0);
                    end else if (!ro && !(cur_pos == 9'd0 && i_req.write_data == 8'd0)) begin
                        rsp.buffer_access = fdcr_pkg::ACC_STORE;
                    end
                end
                if (rsp.buffer_access != fdcr_pkg::ACC_NONE) begin
                    rsp.access_drive  = r_sel_drive;
                    rsp.access_track  = cur_trk;
                    rsp.access_sector = cur_sec;
                    rsp.access_index  = cur_pos;
                    pos_we            = 1'b1;
                end
            end
            fdcr_pkg::REG_SECTOR: begin
                if (disk && !i_req.action) begin
                    rsp.read_data = {4'd0, cur_sec};
                end
            end
            fdcr_pkg::REG_DRIVE: begin
                if (!i_req.action) begin
                    rsp.read_data = {r_sel_drive, 6'b001000};
                    if (disk) begin
                        rsp.read_data[0] = !ro;
                        rsp.read_data[1] = (cur_trk != 6'd0);
                        rsp.read_data[5] = (sec_after == 4'd0);
                        if (r_countdown != 2'd0) begin
                            rsp.read_data[4] = 1'b1;
                            n_countdown      = r_countdown - 2'd1;
                        end else begin
                            // Sector pulse: next sector comes under the head.
                            n_countdown = fdcr_pkg::PULSE_RELOAD;
                            sec_we      = 1'b1;
                            pos_we      = 1'b1;
                            pos_val     = 9'd0;
                        end
                    end
                end else begin
                    n_sel_drive = new_drv;
                    n_countdown = 2'd0;
                    if (i_req.write_data[5]) begin
                        n_step_latch = 1'b1;
                    end else if (r_step_latch) begin
                        // Step on the falling edge of the step bit.
                        n_step_latch = 1'b0;
                        step_we      = ({1'b0, new_drv} < 3'(DRIVES));
                    end
                end
            end
            fdcr_pkg::REG_RESTART: begin
                if (disk) begin
                    pos_we  = 1'b1;
                    pos_val = 9'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < DRIVES; i++) begin
            n_trk[i] = r_trk[i];
            n_sec[i] = r_sec[i];
            n_pos[i] = r_pos[i];
            if (r_sel_drive == 2'(i)) begin
                if (pos_we) begin
                    n_pos[i] = pos_val;
                end
                if (sec_we) begin
                    n_sec[i] = sec_after;
                end
            end
            if (step_we && new_drv == 2'(i)) begin
                n_trk[i] = fdcr_pkg::f_step_track(stp_trk, i_req.write_data[4]);
                n_sec[i] = fdcr_pkg::f_next_sector(stp_sec);
                n_pos[i] = 9'd0;
            end
        end
    end

    assign o_rsp = rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached  <= '0;
            r_read_only <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fdcr_pkg::CFG_ATTACHED:  r_attached  <= i_cfg_wdata;
                fdcr_pkg::CFG_READ_ONLY: r_read_only <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_drive  <= '0;
            r_countdown  <= '0;
            r_step_latch <= 1'b0;
            for (int i = 0; i < DRIVES; i++) begin
                r_trk[i] <= '0;
                r_sec[i] <= '0;
                r_pos[i] <= '0;
            end
        end else if (i_fire) begin
            r_sel_drive  <= n_sel_drive;
            r_countdown  <= n_countdown;
            r_step_latch <= n_step_latch;
            for (int i = 0; i < DRIVES; i++) begin
                r_trk[i] <= n_trk[i];
                r_sec[i] <= n_sec[i];
                r_pos[i] <= n_pos[i];
            end
        end
    end

endmodule

/* hw/rtl/fdcr_out_stage.sv */
`timescale 1ns / 1ps
// Result register toward the output stream.
module fdcr_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  fdcr_pkg::t_rsp     i_rsp,
    input  logic               i_ready,
    output logic               o_valid,
    output fdcr_pkg::t_rsp     o_rsp,
    output logic               o_can_load
);

    logic           r_valid;
    fdcr_pkg::t_rsp r_rsp;

    // The register can take a new result when empty or being emptied now.
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_rsp      = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

/* hw/rtl/floppy_controller_registers_top.sv */
`timescale 1ns / 1ps
// Top level of the floppy controller register block.
//
// The input stream carries one processor bus request per item: tuser holds the
// read/write flag and the register address, tdata holds the written byte. The
// output stream returns exactly one result per request: the byte read and, for
// data-port accesses, a fetch or store request for the sector buffer with the
// drive, track, sector and byte position it applies to.
// A request is taken into an input register, decoded against the controller
// state by combinational logic and lands in the result register, from which
// it is offered on the output. A new request is accepted in every cycle as
// long as results are taken, so the sustained rate is one request per clock.
// When the receiver stalls, the result register holds its contents; the input
// register still takes one more request, and then input ready falls until the
// result register empties.
// Reset clears the selected drive, pulse countdown, step latch, every drive's
// track, sector and position, both configuration masks and both registers'
// valid flags. The masks are written through the configuration port; the user
// must write them only while the block is idle, the block does not enforce it.
module floppy_controller_registers_top #(
    parameter int DRIVES = fdcr_pkg::DRIVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,   // 0 attached mask, 1 read-only mask
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] write_data
    input  logic [3:0]  i_s_tuser,    // [0] action, [3:1] reg_addr
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [7:0] read_data, [9:8] access_drive,
                                      // [15:10] access_track, [19:16] access_sector,
                                      // [28:20] access_index, [31:29] zero
    output logic [2:0]  o_m_tuser     // [1:0] buffer_access, [2] sector_reload
);

    fdcr_pkg::t_req in_req;
    fdcr_pkg::t_req held_req;
    fdcr_pkg::t_rsp core_rsp;
    fdcr_pkg::t_rsp out_rsp;
    logic           held_valid;
    logic           can_load;
    logic           fire;

    assign in_req.action     = i_s_tuser[0];
    assign in_req.reg_addr   = i_s_tuser[3:1];
    assign in_req.write_data = i_s_tdata;

    // A held request is processed whenever the result register has room.
    assign fire = held_valid && can_load;

    fdcr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_req   (in_req),
        .i_take  (fire),
        .o_ready (o_s_tready),
        .o_valid (held_valid),
        .o_req   (held_req)
    );

    fdcr_core #(
        .DRIVES (DRIVES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_req       (held_req),
        .o_rsp       (core_rsp)
    );

    fdcr_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_rsp      (core_rsp),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_rsp      (out_rsp),
        .o_can_load (can_load)
    );

    assign o_m_tdata = {3'd0, out_rsp.access_index, out_rsp.access_sector,
                        out_rsp.access_track, out_rsp.access_drive, out_rsp.read_data};
    assign o_m_tuser = {out_rsp.sector_reload, out_rsp.buffer_access};

endmodule

/* hw/rtl/fdcr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the floppy controller register block and their binding.
module fdcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    // Without a buffer access the place fields and the reload flag are zero.
    a_no_access_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] == fdcr_pkg::ACC_NONE
        |-> o_m_tdata[31:8] == 24'd0 && !o_m_tuser[2])
        else $error("place fields set without a buffer access");

    // A sector reload only comes with a fetch at the start of the sector.
    a_reload_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2]
        |-> o_m_tuser[1:0] == fdcr_pkg::ACC_FETCH && o_m_tdata[28:20] == 9'd0)
        else $error("sector reload outside a fetch at position zero");

    // Buffer accesses never carry data bytes back to the processor.
    a_access_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] != fdcr_pkg::ACC_NONE
        |-> o_m_tdata[7:0] == 8'd0 && o_m_tuser[1:0] != 2'd3)
        else $error("buffer access with read data or unknown code");

endmodule

bind floppy_controller_registers_top fdcr_checker u_fdcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
